>>> hw/rtl/ssdf_pkg.sv
// Shared types and constants for the seven-segment display formatter.
// Holds the command and result transfer structs, the kind codes and the glyph table.
// No dependencies.
`default_nettype none

package ssdf_pkg;

  // Binary width of a numeric operand and the shift-and-add split over the pipeline
  localparam int BIN_W         = 32;
  localparam int DABBLE_STEPS  = 4;
  localparam int DABBLE_STAGES = BIN_W / DABBLE_STEPS;

  // Command kinds
  typedef enum logic [2:0] {
    KIND_RAW        = 3'd0,
    KIND_HEX_DIGIT  = 3'd1,
    KIND_DIRECT     = 3'd2,
    KIND_HEX_NUMBER = 3'd3,
    KIND_DECIMAL    = 3'd4
  } kind_t;

  // One command transfer
  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       position;
    logic [BIN_W-1:0] value_low;
    logic [BIN_W-1:0] value_high;
  } cmd_t;

  // One display register write
  typedef struct packed {
    logic [3:0] grid_register;
    logic [7:0] segments;
    logic       last;
  } result_t;

  // Hex digit to segment pattern
  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] seg;
    unique case (nib)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssdf_dabble.sv
// One pipeline stage of the binary to BCD converter (shift-and-add-3).
// Carries the command alongside; depends on ssdf_pkg.
`default_nettype none

module ssdf_dabble import ssdf_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cmd_t                  in_cmd,
  input  wire logic [4*DIGITS-1:0]   in_bcd,
  input  wire logic [BIN_W-1:0]      in_bin,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cmd_t                       out_cmd,
  output logic [4*DIGITS-1:0]        out_bcd,
  output logic [BIN_W-1:0]           out_bin
);

  localparam int BCD_W = 4 * DIGITS;

  logic [BCD_W-1:0] bcd_next;
  logic [BIN_W-1:0] bin_next;

  // DABBLE_STEPS correct-then-shift steps; digits above DIGITS drop out, giving mod 10^DIGITS
  always_comb begin
    bcd_next = in_bcd;
    bin_next = in_bin;
    for (int s = 0; s < DABBLE_STEPS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      if (BCD_W > 1) begin
        bcd_next = {bcd_next[BCD_W-2:0], bin_next[BIN_W-1]};
      end
      bin_next = {bin_next[BIN_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_cmd <= in_cmd;
      out_bcd <= bcd_next;
      out_bin <= bin_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssdf_format.sv
// Formatting stage: turns a command and its decimal digits into segment bytes.
// Depends on ssdf_pkg (types, glyph table).
`default_nettype none

module ssdf_format import ssdf_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cmd_t                  in_cmd,
  input  wire logic [4*DIGITS-1:0]   in_bcd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [8*DIGITS-1:0]        out_segs,
  output logic                       out_single,
  output logic [2:0]                 out_position
);

  logic [8*DIGITS-1:0] segs_next;
  logic [2*BIN_W-1:0]  bytes;
  logic                single_next;

  assign bytes = {in_cmd.value_high, in_cmd.value_low};

  // Segment bytes per kind; single-digit kinds use slot 0
  always_comb begin
    segs_next   = '0;
    single_next = 1'b0;
    unique case (in_cmd.kind)
      KIND_RAW: begin
        segs_next[7:0] = in_cmd.value_low[7:0];
        single_next    = 1'b1;
      end
      KIND_HEX_DIGIT: begin
        segs_next[7:0] = glyph(in_cmd.value_low[3:0]);
        single_next    = 1'b1;
      end
      KIND_DIRECT: begin
        for (int i = 0; i < DIGITS; i++) begin
          segs_next[8*i +: 8] = bytes[8*i +: 8];
        end
      end
      KIND_HEX_NUMBER: begin
        for (int i = 0; i < DIGITS; i++) begin
          segs_next[8*i +: 8] = glyph(in_cmd.value_low[4*i +: 4]);
        end
      end
      KIND_DECIMAL: begin
        for (int i = 0; i < DIGITS; i++) begin
          segs_next[8*i +: 8] = glyph(in_bcd[4*i +: 4]);
        end
      end
      default: begin
        segs_next   = '0;
        single_next = 1'b1;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_segs     <= segs_next;
      out_single   <= single_next;
      out_position <= in_cmd.position;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssdf_serializer.sv
// Output serializer: emits one display register write per cycle from a formatted item.
// Depends on ssdf_pkg (result_t).
`default_nettype none

module ssdf_serializer import ssdf_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [8*DIGITS-1:0]   in_segs,
  input  wire logic                  in_single,
  input  wire logic [2:0]            in_position,
  output logic                       strobe,
  output result_t                    result
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                active;
  logic [IDX_W-1:0]    idx;
  logic [8*DIGITS-1:0] segs;
  logic                single;
  logic [2:0]          position;
  logic                last_write;
  logic [2:0]          pos_now;

  // Current write
  assign last_write = single || (idx == IDX_W'(DIGITS - 1));
  assign pos_now    = single ? position : 3'(idx);
  assign strobe     = active;
  assign result.grid_register = {~pos_now, 1'b0};
  assign result.segments      = segs[8*idx +: 8];
  assign result.last          = last_write;

  // Take the next item in the cycle the current one finishes
  assign in_ready = !active || last_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (in_ready) begin
      active <= in_valid;
      idx    <= '0;
    end else begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      segs     <= in_segs;
      single   <= in_single;
      position <= in_position;
    end
  end

  // Single-digit items are always a lone write
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    active && single |-> result.last)
    else $error("single-digit write without last");

  // A multi-write item continues without gaps, stepping the digit index
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    active && !last_write |=> active && (idx == IDX_W'($past(idx) + 1'b1)))
    else $error("serializer dropped or repeated a digit");

  // Nothing is emitted right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("strobe after reset");

endmodule

`default_nettype wire

>>> hw/rtl/seven_segment_display_formatter.sv
// Formats commands into display register writes for an eight-digit seven-segment
// grid: raw or hex digit at one position, direct bytes, hex number or decimal number.
// A command is taken when start is high and busy low; writes come out one per cycle,
// marked by strobe, and the receiver cannot stall them. Single-digit commands produce
// one write, multi-digit commands produce DIGITS writes, unknown kinds produce none.
// The output serializer sets the rate, as it holds each command for all of its writes,
// with a new command accepted every cycle while the pipeline has room. The first write
// of a command reaches the result ports after ten register stages (eight
// binary-to-decimal stages, one formatting stage, one output stage).
`default_nettype none

module seven_segment_display_formatter import ssdf_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         strobe,
  output result_t      result
);

  localparam int BCD_W = 4 * DIGITS;

  logic                kind_ok;
  logic                dab_valid [DABBLE_STAGES+1];
  logic                dab_ready [DABBLE_STAGES+1];
  cmd_t                dab_cmd   [DABBLE_STAGES+1];
  logic [BCD_W-1:0]    dab_bcd   [DABBLE_STAGES+1];
  logic [BIN_W-1:0]    dab_bin   [DABBLE_STAGES+1];
  logic                fmt_valid;
  logic                fmt_ready;
  logic [8*DIGITS-1:0] fmt_segs;
  logic                fmt_single;
  logic [2:0]          fmt_position;

  // Unknown kinds are taken and dropped
  assign kind_ok = (cmd.kind == KIND_RAW) || (cmd.kind == KIND_HEX_DIGIT) ||
                   (cmd.kind == KIND_DIRECT) || (cmd.kind == KIND_HEX_NUMBER) ||
                   (cmd.kind == KIND_DECIMAL);

  assign dab_valid[0] = start && kind_ok;
  assign dab_cmd[0]   = cmd;
  assign dab_bcd[0]   = '0;
  assign dab_bin[0]   = cmd.value_low;
  assign busy         = !dab_ready[0];

  // Binary to decimal pipeline
  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    ssdf_dabble #(.DIGITS(DIGITS)) u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dab_valid[g]),
      .in_ready  (dab_ready[g]),
      .in_cmd    (dab_cmd[g]),
      .in_bcd    (dab_bcd[g]),
      .in_bin    (dab_bin[g]),
      .out_valid (dab_valid[g+1]),
      .out_ready (dab_ready[g+1]),
      .out_cmd   (dab_cmd[g+1]),
      .out_bcd   (dab_bcd[g+1]),
      .out_bin   (dab_bin[g+1])
    );
  end

  // Segment formatting
  ssdf_format #(.DIGITS(DIGITS)) u_format (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dab_valid[DABBLE_STAGES]),
    .in_ready     (dab_ready[DABBLE_STAGES]),
    .in_cmd       (dab_cmd[DABBLE_STAGES]),
    .in_bcd       (dab_bcd[DABBLE_STAGES]),
    .out_valid    (fmt_valid),
    .out_ready    (fmt_ready),
    .out_segs     (fmt_segs),
    .out_single   (fmt_single),
    .out_position (fmt_position)
  );

  // One write per cycle
  ssdf_serializer #(.DIGITS(DIGITS)) u_serializer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (fmt_valid),
    .in_ready    (fmt_ready),
    .in_segs     (fmt_segs),
    .in_single   (fmt_single),
    .in_position (fmt_position),
    .strobe      (strobe),
    .result      (result)
  );

endmodule

`default_nettype wire

>>> tb/sv/seven_segment_display_formatter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_display_formatter: directed commands, then
// random ones, each predicted as display register writes and compared as they strobe out.
// Depends on ssdf_pkg (cmd_t, result_t, kind codes) and the formatter RTL.

module seven_segment_display_formatter_tb;
  import ssdf_pkg::*;

  localparam int DIGITS = 8;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 250;
  localparam int BURST_LEN = 25;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 60;
  localparam logic [31:0] DEC_SPAN = 32'd100000000;

  // Kind codes with no meaning; the formatter drops them
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

  // One row of the directed table; typed rows carry their write in the row
  typedef struct {
    cmd_t    c;
    bit      typed;
    bit      has_write;
    result_t w;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    strobe;
  result_t result;

  result_t   pending_writes[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // Segment patterns for hex digits 0..F
  logic [7:0] seg_font [16] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                                8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71};

  seven_segment_display_formatter #(
    .DIGITS(DIGITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  // Register writes a command should produce; position p lands on grid (7-p)*2 = {~p,0}
  task automatic predict_writes(input cmd_t c);
    logic [31:0] num;
    logic [7:0]  seg;
    logic [2:0]  p;
    num = c.value_low;
    case (c.kind)
      KIND_RAW:
        pending_writes.push_back(result_t'{{~c.position, 1'b0}, c.value_low[7:0], 1'b1});
      KIND_HEX_DIGIT:
        pending_writes.push_back(
          result_t'{{~c.position, 1'b0}, seg_font[c.value_low[3:0]], 1'b1});
      KIND_DIRECT, KIND_HEX_NUMBER, KIND_DECIMAL: begin
        for (int d = 0; d < DIGITS; d++) begin
          p = d[2:0];
          if (c.kind == KIND_DIRECT) begin
            seg = (d < 4) ? c.value_low[8*d +: 8] : c.value_high[8*(d-4) +: 8];
          end else if (c.kind == KIND_HEX_NUMBER) begin
            seg = seg_font[num[3:0]];
            num = num >> 4;
          end else begin
            seg = seg_font[4'(num % 32'd10)];
            num = num / 32'd10;
          end
          pending_writes.push_back(result_t'{{~p, 1'b0}, seg, d == DIGITS - 1});
        end
      end
      default: ;
    endcase
  endtask

  // Present a command until the transfer happens; start stays high for the caller
  task automatic send_cmd(input cmd_t c, input bit typed, input bit has_write,
                          input result_t w);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!typed)
      predict_writes(c);
    else if (has_write)
      pending_writes.push_back(w);
  endtask

  // Sender idle time: mostly none or short, now and then long
  task automatic sender_gap(input bit gappy);
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = 0;
    if (gappy) begin
      if (r >= 9)      n = $urandom_range(10, 40);
      else if (r >= 5) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      cmd   <= cmd_t'({$urandom, $urandom, $urandom});
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [2:0] k, input logic [2:0] pos, input logic [31:0] lo,
                         input logic [31:0] hi, input bit typed, input bit has_write,
                         input logic [3:0] grid, input logic [7:0] seg);
    stim_row_t row;
    row.c         = '{k, pos, lo, hi};
    row.typed     = typed;
    row.has_write = has_write;
    row.w         = result_t'{grid, seg, 1'b1};
    directed_rows.push_back(row);
  endtask

  // Random command, weighted toward multi-digit kinds and decimal edge values
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    c = cmd_t'({$urandom, $urandom, $urandom});
    r = $urandom_range(0, 19);
    if (r < 3)       c.kind = KIND_RAW;
    else if (r < 6)  c.kind = KIND_HEX_DIGIT;
    else if (r < 9)  c.kind = KIND_DIRECT;
    else if (r < 12) c.kind = KIND_HEX_NUMBER;
    else if (r < 18) c.kind = KIND_DECIMAL;
    else             c.kind = 3'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO));
    if (c.kind == KIND_DECIMAL) begin
      case ($urandom_range(0, 3))
        0: c.value_low = $urandom_range(999, 0);
        1: c.value_low = $urandom_range(DEC_SPAN - 1, 0);
        2: c.value_low = DEC_SPAN * $urandom_range(42, 0) + $urandom_range(2, 0) - 1;
        default: ;
      endcase
    end
    return c;
  endfunction

  // Result checker; strobe and result are sampled before this edge updates them
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with none pending", 0, result);
      end else begin
        want = pending_writes.pop_front();
        if (result.grid_register != want.grid_register)
          report_mismatch("grid_register", want.grid_register, result.grid_register);
        if (result.segments != want.segments)
          report_mismatch("segments", want.segments, result.segments);
        if (result.last != want.last)
          report_mismatch("last", want.last, result.last);
      end
    end
  end

  initial begin
    int     sent;
    bit     gappy;
    cmd_t   c;

    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;

    // Directed commands: extremes, every kind, truncation and wrap cases
    add_row(KIND_RAW,        3'd0, 32'h0000_0000, 32'h0000_0000, 1, 1, 4'd14, 8'h00);
    add_row(KIND_RAW,        3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 4'd0,  8'hFF);
    add_row(KIND_RAW,        3'd3, 32'h0123_45A5, 32'h0000_0000, 1, 1, 4'd8,  8'hA5);
    add_row(KIND_HEX_DIGIT,  3'd0, 32'h0000_0000, 32'h0000_0000, 1, 1, 4'd14, 8'h3F);
    add_row(KIND_HEX_DIGIT,  3'd7, 32'h0000_000F, 32'hFFFF_FFFF, 1, 1, 4'd0,  8'h71);
    add_row(KIND_HEX_DIGIT,  3'd5, 32'hFFFF_FFFA, 32'h0000_0000, 1, 1, 4'd4,  8'h77);
    add_row(KIND_DIRECT,     3'd0, 32'h0302_0100, 32'h0706_0504, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DIRECT,     3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DIRECT,     3'd2, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 4'd0,  8'h00);
    add_row(KIND_HEX_NUMBER, 3'd0, 32'h7654_3210, 32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_HEX_NUMBER, 3'd7, 32'hFEDC_BA98, 32'hFFFF_FFFF, 0, 0, 4'd0,  8'h00);
    add_row(KIND_HEX_NUMBER, 3'd1, 32'h0000_0000, 32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DECIMAL,    3'd0, 32'd0,         32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DECIMAL,    3'd4, 32'd99999999,  32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DECIMAL,    3'd6, 32'd100000000, 32'hFFFF_FFFF, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DECIMAL,    3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(KIND_DECIMAL,    3'd2, 32'd12345678,  32'h0000_0000, 0, 0, 4'd0,  8'h00);
    add_row(3'd5,            3'd0, 32'h0000_0001, 32'h0000_0000, 1, 0, 4'd0,  8'h00);
    add_row(3'd6,            3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 4'd0,  8'h00);
    add_row(KIND_RESERVED_HI, 3'd7, 32'h1234_5678, 32'h9ABC_DEF0, 1, 0, 4'd0, 8'h00);
    add_row(KIND_RAW,        3'd1, 32'h0000_0080, 32'h0000_0000, 1, 1, 4'd12, 8'h80);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].has_write,
               directed_rows[i].w);
      sender_gap(i % 2);
    end
    drain_writes();

    // Random commands in bursts, some back to back, some with idle gaps
    sent  = 0;
    gappy = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % BURST_LEN == 0) gappy = $urandom_range(0, 2) != 0;
      if (sent == RANDOM_ITEMS / 2) drain_writes();
      c = rand_cmd();
      send_cmd(c, 1'b0, 1'b0, '0);
      if (c.kind <= KIND_DECIMAL) sent++;
      sender_gap(gappy);
    end

    drain_writes();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
